### rtl/fbc_pkg.sv
// Shared types, constants and functions for the Feistel block cipher pipeline.
package fbc_pkg;

    // Block, half and key widths and the default round count
    localparam int HALF_W   = 32;
    localparam int BLOCK_W  = 2 * HALF_W;
    localparam int KEY_W    = 32;
    localparam int ROUNDS_DEF = 16;

    // Command codes
    localparam logic CMD_ENCRYPT = 1'b0;
    localparam logic CMD_DECRYPT = 1'b1;

    // One pipeline slot: valid flag, direction and the two halves
    typedef struct packed {
        logic              valid;
        logic              decrypt;
        logic [HALF_W-1:0] left;
        logic [HALF_W-1:0] right;
    } stage_t;

    // AES forward S-box
    localparam logic [7:0] SBOX_TAB [0:255] = '{
        8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5,
        8'h30, 8'h01, 8'h67, 8'h2b, 8'hfe, 8'hd7, 8'hab, 8'h76,
        8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
        8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0,
        8'hb7, 8'hfd, 8'h93, 8'h26, 8'h36, 8'h3f, 8'hf7, 8'hcc,
        8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
        8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a,
        8'h07, 8'h12, 8'h80, 8'he2, 8'heb, 8'h27, 8'hb2, 8'h75,
        8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
        8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84,
        8'h53, 8'hd1, 8'h00, 8'hed, 8'h20, 8'hfc, 8'hb1, 8'h5b,
        8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
        8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85,
        8'h45, 8'hf9, 8'h02, 8'h7f, 8'h50, 8'h3c, 8'h9f, 8'ha8,
        8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
        8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2,
        8'hcd, 8'h0c, 8'h13, 8'hec, 8'h5f, 8'h97, 8'h44, 8'h17,
        8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
        8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88,
        8'h46, 8'hee, 8'hb8, 8'h14, 8'hde, 8'h5e, 8'h0b, 8'hdb,
        8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
        8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79,
        8'he7, 8'hc8, 8'h37, 8'h6d, 8'h8d, 8'hd5, 8'h4e, 8'ha9,
        8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
        8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6,
        8'he8, 8'hdd, 8'h74, 8'h1f, 8'h4b, 8'hbd, 8'h8b, 8'h8a,
        8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
        8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e,
        8'he1, 8'hf8, 8'h98, 8'h11, 8'h69, 8'hd9, 8'h8e, 8'h94,
        8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
        8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68,
        8'h41, 8'h99, 8'h2d, 8'h0f, 8'hb0, 8'h54, 8'hbb, 8'h16
    };

    // Rotate left by a fixed amount (0..31); a zero shift leaves the value alone
    function automatic logic [KEY_W-1:0] rotl(input logic [KEY_W-1:0] v, input int n);
        logic [KEY_W-1:0] r;
        r = (n % KEY_W == 0) ? v : ((v << (n % KEY_W)) | (v >> (KEY_W - (n % KEY_W))));
        return r;
    endfunction

    // Round function: key mix then byte-wise S-box
    function automatic logic [HALF_W-1:0] round_f(input logic [HALF_W-1:0] half,
                                                  input logic [KEY_W-1:0]  rk);
        logic [HALF_W-1:0] x;
        logic [HALF_W-1:0] y;
        x = half ^ rk;
        for (int b = 0; b < HALF_W / 8; b++) begin
            y[b*8 +: 8] = SBOX_TAB[x[b*8 +: 8]];
        end
        return y;
    endfunction

endpackage

### rtl/fbc_round.sv
// One Feistel round with its output register: a single pipeline stage.
module fbc_round #(
    parameter int ROUNDS    = fbc_pkg::ROUNDS_DEF,
    parameter int STAGE_IDX = 0
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic [fbc_pkg::KEY_W-1:0]  key,
    input  fbc_pkg::stage_t            stage_in,
    output fbc_pkg::stage_t            stage_out
);
    import fbc_pkg::*;

    // Round keys for both directions are fixed rotations of the key
    localparam int ENC_ROT = STAGE_IDX;
    localparam int DEC_ROT = ROUNDS - 1 - STAGE_IDX;

    logic              valid_reg;
    logic              decrypt_reg;
    logic [HALF_W-1:0] left_reg;
    logic [HALF_W-1:0] right_reg;
    logic [HALF_W-1:0] left_next;
    logic [HALF_W-1:0] right_next;
    logic [KEY_W-1:0]  enc_key;
    logic [KEY_W-1:0]  dec_key;

    assign enc_key = rotl(key, ENC_ROT);
    assign dec_key = rotl(key, DEC_ROT);

    // Encrypt: L' = R, R' = L ^ F(R). Decrypt: R' = L, L' = R ^ F(L).
    always_comb
    begin
        if (stage_in.decrypt == CMD_DECRYPT)
        begin
            left_next  = stage_in.right ^ round_f(stage_in.left, dec_key);
            right_next = stage_in.left;
        end
        else
        begin
            left_next  = stage_in.right;
            right_next = stage_in.left ^ round_f(stage_in.right, enc_key);
        end
    end

    // Valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= stage_in.valid;
        end
    end

    // Payload, loaded only with a live transaction
    always_ff @(posedge clk)
    begin
        if (stage_in.valid)
        begin
            decrypt_reg <= stage_in.decrypt;
            left_reg    <= left_next;
            right_reg   <= right_next;
        end
    end

    assign stage_out.valid   = valid_reg;
    assign stage_out.decrypt = decrypt_reg;
    assign stage_out.left    = left_reg;
    assign stage_out.right   = right_reg;

endmodule

### rtl/feistel_block_cipher.sv
// Top level of the pipelined Feistel block cipher.
//
//  channel  | handshake                 | payload
//  ---------+---------------------------+---------------------------
//  input    | start, busy (always low)  | command, data_block
//  result   | done (one-cycle strobe)   | result_block
//  key      | cfg_valid, cfg_ready      | cipher_key
//
// One round per register stage: a block enters every cycle and its result
// leaves the last round stage register, one result per clock at full rate.
// The delay is set by the round chain, one S-box round per stage.
// Reset clears the valid flags and the key. Results cannot be held off, so
// nothing stalls; a key write is taken only while no block is in flight.
module feistel_block_cipher #(
    parameter int ROUNDS = fbc_pkg::ROUNDS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic                         command,
    input  logic [fbc_pkg::BLOCK_W-1:0]  data_block,
    output logic                         done,
    output logic [fbc_pkg::BLOCK_W-1:0]  result_block,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [fbc_pkg::KEY_W-1:0]    cipher_key
);
    import fbc_pkg::*;

    stage_t           pipe [0:ROUNDS];
    logic [ROUNDS:1]  live;
    logic [KEY_W-1:0] key_reg;

    // Pipeline never stalls
    assign busy = 1'b0;

    // Entry slot
    assign pipe[0].valid   = start & ~busy;
    assign pipe[0].decrypt = command;
    assign pipe[0].left    = data_block[BLOCK_W-1:HALF_W];
    assign pipe[0].right   = data_block[HALF_W-1:0];

    // Round stages
    for (genvar i = 0; i < ROUNDS; i++) begin : g_round
        fbc_round #(
            .ROUNDS    (ROUNDS),
            .STAGE_IDX (i)
        ) u_round (
            .clk       (clk),
            .rst_n     (rst_n),
            .key       (key_reg),
            .stage_in  (pipe[i]),
            .stage_out (pipe[i+1])
        );
        assign live[i+1] = pipe[i+1].valid;
    end

    // Key register: writable only with the pipeline empty
    assign cfg_ready = ~start & ~(|live);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            key_reg <= cipher_key;
        end
    end

    // Result strobe and data straight from the last stage register
    assign done         = pipe[ROUNDS].valid;
    assign result_block = {pipe[ROUNDS].left, pipe[ROUNDS].right};

endmodule

### rtl/fbc_chk.sv
// Port-level checker for the Feistel block cipher, bound to the top level.
module fbc_chk #(
    parameter int ROUNDS = fbc_pkg::ROUNDS_DEF
) (
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic done,
    input logic cfg_valid,
    input logic cfg_ready
);
    // Every accepted block yields a result once it has passed the round stages
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##ROUNDS done)
        else $error("result missing after accepted block");

    // No result without a matching block accepted before it
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, ROUNDS))
        else $error("result without a matching block");

    // Key cannot change while a result is still on its way out
    a_key_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !cfg_ready)
        else $error("key port ready with blocks in flight");

    // A key write never coincides with a block entering
    a_key_vs_start: assert property (@(posedge clk) disable iff (!rst_n)
        (cfg_valid && cfg_ready) |-> !start)
        else $error("key written in the cycle a block entered");

endmodule

bind feistel_block_cipher fbc_chk #(.ROUNDS(ROUNDS)) u_fbc_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .done      (done),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready)
);
